### rtl/core/assert_macros.svh
// Assertion macros used by the quaternion unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define QALU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("qalu assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define QALU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qalu assertion failed");
`else
`define QALU_ASSERT(label, clk, rst, prop)
`define QALU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/qalu_pkg.sv
// Types and constants of the quaternion unit.
package qalu_pkg;

   // operation codes
   localparam logic [1:0] CMD_MUL  = 2'd0;
   localparam logic [1:0] CMD_ROT  = 2'd1;
   localparam logic [1:0] CMD_CONJ = 2'd2;

   // component places inside a quaternion array
   localparam int IX = 0;
   localparam int IY = 1;
   localparam int IZ = 2;
   localparam int IW = 3;

   typedef logic signed [31:0] qalu_comp_type;

   localparam qalu_comp_type MAX_Q = 32'sh7fff_ffff;
   localparam qalu_comp_type MIN_Q = 32'sh8000_0000;

   // transfer between the front half and the rotate back half
   typedef struct packed {
      logic [1:0]              cmd;
      qalu_comp_type [3:0]     a;
      qalu_comp_type [3:0]     b;
      qalu_comp_type [3:0]     r;
      logic                    r_ov;
      qalu_comp_type [2:0]     c;
      logic                    c_ov;
   } qalu_mid_type;

endpackage

### rtl/core/qalu_if.sv
// Request and response channel interfaces of the quaternion unit.
interface qalu_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic signed [31:0]  a_x;
   logic signed [31:0]  a_y;
   logic signed [31:0]  a_z;
   logic signed [31:0]  a_w;
   logic signed [31:0]  b_x;
   logic signed [31:0]  b_y;
   logic signed [31:0]  b_z;
   logic signed [31:0]  b_w;

   modport source (
      output valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
      input  ready
   );
   modport sink (
      input  valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
      output ready
   );
endinterface

interface qalu_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  r_x;
   logic signed [31:0]  r_y;
   logic signed [31:0]  r_z;
   logic signed [31:0]  r_w;
   logic                overflow;

   modport source (
      output valid, r_x, r_y, r_z, r_w, overflow,
      input  ready
   );
   modport sink (
      input  valid, r_x, r_y, r_z, r_w, overflow,
      output ready
   );
endinterface

### rtl/core/quaternion_alu_top.sv
// Top level of the quaternion unit: front half plus the rotate back half.
// Throughput: one item per cycle while the response side does not stall; seven register stages, each with a valid bit.
// A stage refills as soon as its content moves on, so bubbles are squeezed out.
// Reset (synchronous) clears every stage valid; data registers are not reset.
`include "assert_macros.svh"
module quaternion_alu_top import qalu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   qalu_req_if.sink   req,
   qalu_rsp_if.source rsp
);

   localparam int RPW = 65 - FRAC_BITS;  // doubled product width
   localparam int RSW = RPW + 2;         // vector plus three products

   // floor(2*p*q / 2^FRAC_BITS)
   function automatic logic signed [RPW-1:0] dmul(input qalu_comp_type p,
                                                   input qalu_comp_type q);
      logic signed [63:0] full;
      full = 64'(p) * 64'(q);
      return RPW'(full >>> (FRAC_BITS - 1));
   endfunction

   function automatic logic rsum_ov(input logic signed [RSW-1:0] v);
      logic [RSW-32:0] hi;
      hi = v[RSW-1:31];
      return !((&hi) || (~|hi));
   endfunction

   function automatic qalu_comp_type rsum_sat(input logic signed [RSW-1:0] v);
      qalu_comp_type res;
      if (!rsum_ov(v)) begin
         res = v[31:0];
      end else if (v[RSW-1]) begin
         res = MIN_Q;
      end else begin
         res = MAX_Q;
      end
      return res;
   endfunction

   logic         mid_valid;
   logic         mid_ready;
   qalu_mid_type mid;

   qalu_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid       (mid)
   );

   // back half valids and enables
   logic b1_v_ff, b2_v_ff, rsp_valid_ff;
   logic en1, en2, en3;

   assign en3 = !rsp_valid_ff || rsp.ready;
   assign en2 = !b2_v_ff || en3;
   assign en1 = !b1_v_ff || en2;
   assign mid_ready = en1;

   // stage 5: doubled products of the rotation
   qalu_mid_type          b1_mid_ff;
   logic signed [RPW-1:0] qw_in [3];
   logic signed [RPW-1:0] qp_in [3];
   logic signed [RPW-1:0] qn_in [3];
   logic signed [RPW-1:0] b1_qw_ff [3];
   logic signed [RPW-1:0] b1_qp_ff [3];
   logic signed [RPW-1:0] b1_qn_ff [3];

   // stage 6: rotation sums
   qalu_mid_type          b2_mid_ff;
   logic signed [RSW-1:0] rs_in [3];
   logic signed [RSW-1:0] b2_rs_ff [3];

   // stage 7: response register
   logic [1:0]    rsp_cmd_ff;
   qalu_comp_type rsp_r_in [4];
   logic          rsp_ov_in;
   qalu_comp_type rsp_r_ff [4];
   logic          rsp_ov_ff;

   // advance valids
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff      <= 1'b0;
         b2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) b1_v_ff      <= mid_valid;
         if (en2) b2_v_ff      <= b1_v_ff;
         if (en3) rsp_valid_ff <= b2_v_ff;
      end
   end

   // a.w*c and both cross terms of a.v x c
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         qw_in[j] = dmul(mid.a[IW], mid.c[j]);
         qp_in[j] = dmul(mid.a[(j + 1) % 3], mid.c[(j + 2) % 3]);
         qn_in[j] = dmul(mid.a[(j + 2) % 3], mid.c[(j + 1) % 3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         b1_mid_ff <= mid;
         b1_qw_ff  <= qw_in;
         b1_qp_ff  <= qp_in;
         b1_qn_ff  <= qn_in;
      end
   end

   // v + 2*aw*c + 2*(av x c)
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rs_in[j] = RSW'(b1_mid_ff.b[j]) + RSW'(b1_qw_ff[j])
                  + RSW'(b1_qp_ff[j]) - RSW'(b1_qn_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         b2_mid_ff <= b1_mid_ff;
         b2_rs_ff  <= rs_in;
      end
   end

   // saturate the rotation, otherwise pass the front result
   always_comb begin
      rsp_r_in[IW] = '0;
      rsp_ov_in    = 1'b0;
      for (int j = 0; j < 3; j++) begin
         rsp_r_in[j] = '0;
      end
      unique case (b2_mid_ff.cmd)
         CMD_ROT: begin
            rsp_ov_in = b2_mid_ff.c_ov;
            for (int j = 0; j < 3; j++) begin
               rsp_r_in[j] = rsum_sat(b2_rs_ff[j]);
               rsp_ov_in   = rsp_ov_in | rsum_ov(b2_rs_ff[j]);
            end
         end
         default: begin
            for (int i = 0; i < 4; i++) begin
               rsp_r_in[i] = b2_mid_ff.r[i];
            end
            rsp_ov_in = b2_mid_ff.r_ov;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_cmd_ff <= b2_mid_ff.cmd;
         rsp_r_ff   <= rsp_r_in;
         rsp_ov_ff  <= rsp_ov_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.r_x      = rsp_r_ff[IX];
   assign rsp.r_y      = rsp_r_ff[IY];
   assign rsp.r_z      = rsp_r_ff[IZ];
   assign rsp.r_w      = rsp_r_ff[IW];
   assign rsp.overflow = rsp_ov_ff;

   // classify the presented response for the checks below
   logic rsp_cmd_bad;
   logic rsp_all_zero;
   logic rsp_any_max;

   assign rsp_cmd_bad  = rsp_cmd_ff != CMD_MUL && rsp_cmd_ff != CMD_ROT
                      && rsp_cmd_ff != CMD_CONJ;
   assign rsp_all_zero = rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0
                      && rsp.r_w == '0 && !rsp.overflow;
   assign rsp_any_max  = rsp.r_x == MAX_Q || rsp.r_y == MAX_Q || rsp.r_z == MAX_Q;

   // nothing is presented right after reset
   `QALU_ASSERT_NEXT(a_rst_empty, clock, 1'b0, reset, !rsp.valid)
   // rotate returns a pure vector
   `QALU_ASSERT(a_rot_w_zero, clock, reset, rsp.valid && rsp_cmd_ff == CMD_ROT |-> rsp.r_w == '0)
   // an unused code gives an all-zero result
   `QALU_ASSERT(a_bad_cmd_zero, clock, reset, rsp.valid && rsp_cmd_bad |-> rsp_all_zero)
   // conjugate overflows only by clamping a negated minimum to the maximum
   `QALU_ASSERT(a_conj_ov_max, clock, reset, rsp.valid && rsp_cmd_ff == CMD_CONJ && rsp.overflow |-> rsp_any_max)

endmodule

### rtl/core/qalu_front.sv
// Front half: input register, 16 products, Hamilton and cross sums, saturation.
module qalu_front import qalu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   qalu_req_if.sink     req,
   output logic         mid_valid,
   input  logic         mid_ready,
   output qalu_mid_type mid
);

   localparam int PW = 64 - FRAC_BITS;   // floored product width
   localparam int SW = PW + 2;           // sum of four products

   // floor(p*q / 2^FRAC_BITS)
   function automatic logic signed [PW-1:0] fmul(input qalu_comp_type p,
                                                  input qalu_comp_type q);
      logic signed [63:0] full;
      full = 64'(p) * 64'(q);
      return PW'(full >>> FRAC_BITS);
   endfunction

   function automatic logic sum_ov(input logic signed [SW-1:0] v);
      logic [SW-32:0] hi;
      hi = v[SW-1:31];
      return !((&hi) || (~|hi));
   endfunction

   function automatic qalu_comp_type sum_sat(input logic signed [SW-1:0] v);
      qalu_comp_type res;
      if (!sum_ov(v)) begin
         res = v[31:0];
      end else if (v[SW-1]) begin
         res = MIN_Q;
      end else begin
         res = MAX_Q;
      end
      return res;
   endfunction

   // stage valids and enables
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic en1, en2, en3, en4;

   assign en4 = !s4_v_ff || mid_ready;
   assign en3 = !s3_v_ff || en4;
   assign en2 = !s2_v_ff || en3;
   assign en1 = !s1_v_ff || en2;
   assign req.ready = en1;

   // stage 1: input register
   logic [1:0]    s1_cmd_ff;
   qalu_comp_type s1_a_ff [4];
   qalu_comp_type s1_b_ff [4];

   // stage 2: products a[i]*b[j]
   logic [1:0]          s2_cmd_ff;
   qalu_comp_type       s2_a_ff [4];
   qalu_comp_type       s2_b_ff [4];
   logic signed [PW-1:0] pp_in [4][4];
   logic signed [PW-1:0] s2_pp_ff [4][4];

   // stage 3: sums
   logic [1:0]          s3_cmd_ff;
   qalu_comp_type       s3_a_ff [4];
   qalu_comp_type       s3_b_ff [4];
   logic signed [SW-1:0] ham_in [4];
   logic signed [SW-1:0] crs_in [3];
   logic signed [SW-1:0] s3_ham_ff [4];
   logic signed [SW-1:0] s3_crs_ff [3];

   // stage 4: saturated results
   qalu_mid_type mid_in;
   qalu_mid_type mid_ff;

   // advance valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (en1) s1_v_ff <= req.valid;
         if (en2) s2_v_ff <= s1_v_ff;
         if (en3) s3_v_ff <= s2_v_ff;
         if (en4) s4_v_ff <= s3_v_ff;
      end
   end

   // capture the transfer
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_cmd_ff     <= req.cmd;
         s1_a_ff[IX]   <= req.a_x;
         s1_a_ff[IY]   <= req.a_y;
         s1_a_ff[IZ]   <= req.a_z;
         s1_a_ff[IW]   <= req.a_w;
         s1_b_ff[IX]   <= req.b_x;
         s1_b_ff[IY]   <= req.b_y;
         s1_b_ff[IZ]   <= req.b_z;
         s1_b_ff[IW]   <= req.b_w;
      end
   end

   // form every component product
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pp_in[i][j] = fmul(s1_a_ff[i], s1_b_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_a_ff   <= s1_a_ff;
         s2_b_ff   <= s1_b_ff;
         s2_pp_ff  <= pp_in;
      end
   end

   // Hamilton sums and the cross product a.v x b.v
   always_comb begin
      ham_in[IW] = SW'(s2_pp_ff[IW][IW]) - SW'(s2_pp_ff[IX][IX])
                 - SW'(s2_pp_ff[IY][IY]) - SW'(s2_pp_ff[IZ][IZ]);
      for (int j = 0; j < 3; j++) begin
         crs_in[j] = SW'(s2_pp_ff[(j + 1) % 3][(j + 2) % 3])
                   - SW'(s2_pp_ff[(j + 2) % 3][(j + 1) % 3]);
         ham_in[j] = SW'(s2_pp_ff[j][IW]) + SW'(s2_pp_ff[IW][j])
                   + SW'(s2_pp_ff[(j + 1) % 3][(j + 2) % 3])
                   - SW'(s2_pp_ff[(j + 2) % 3][(j + 1) % 3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_cmd_ff <= s2_cmd_ff;
         s3_a_ff   <= s2_a_ff;
         s3_b_ff   <= s2_b_ff;
         s3_ham_ff <= ham_in;
         s3_crs_ff <= crs_in;
      end
   end

   // saturate, pick the multiply or conjugate result, or zero for an unused code
   always_comb begin
      mid_in.cmd  = s3_cmd_ff;
      mid_in.c_ov = 1'b0;
      for (int i = 0; i < 4; i++) begin
         mid_in.a[i] = s3_a_ff[i];
         mid_in.b[i] = s3_b_ff[i];
      end
      for (int j = 0; j < 3; j++) begin
         mid_in.c[j] = sum_sat(s3_crs_ff[j]);
         mid_in.c_ov = mid_in.c_ov | sum_ov(s3_crs_ff[j]);
      end
      mid_in.r    = '0;
      mid_in.r_ov = 1'b0;
      unique case (s3_cmd_ff)
         CMD_MUL: begin
            for (int i = 0; i < 4; i++) begin
               mid_in.r[i] = sum_sat(s3_ham_ff[i]);
               mid_in.r_ov = mid_in.r_ov | sum_ov(s3_ham_ff[i]);
            end
         end
         CMD_CONJ: begin
            for (int j = 0; j < 3; j++) begin
               if (s3_a_ff[j] == MIN_Q) begin
                  mid_in.r[j] = MAX_Q;
                  mid_in.r_ov = 1'b1;
               end else begin
                  mid_in.r[j] = -s3_a_ff[j];
               end
            end
            mid_in.r[IW] = s3_a_ff[IW];
         end
         default: begin
            mid_in.r    = '0;
            mid_in.r_ov = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = s4_v_ff;
   assign mid       = mid_ff;

endmodule

### tb/tb_quaternion_alu_top.sv
// Self-checking testbench for the quaternion unit: multiply, rotate and conjugate over Q16.16.
`timescale 1ns / 100ps

module tb_quaternion_alu_top import qalu_pkg::*;;

   localparam int FRAC = 16;
   localparam int IDLE_PCT = 11;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;
   localparam int RANDOM_ITEMS = 1500;

   // code the block leaves unused; it answers with all zeros
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam qalu_comp_type ONE = 32'sh0001_0000;
   localparam qalu_comp_type HALF_SQRT2 = 32'sd46341;

   typedef struct packed {
      logic [1:0]    cmd;
      qalu_comp_type ax;
      qalu_comp_type ay;
      qalu_comp_type az;
      qalu_comp_type aw;
      qalu_comp_type bx;
      qalu_comp_type by;
      qalu_comp_type bz;
      qalu_comp_type bw;
      logic          hold_for_drain;
   } quat_req_t;

   typedef struct packed {
      qalu_comp_type rx;
      qalu_comp_type ry;
      qalu_comp_type rz;
      qalu_comp_type rw;
      logic          ov;
   } quat_rsp_t;

   logic clock;
   logic reset;

   qalu_req_if req_ch ();
   qalu_rsp_if rsp_ch ();

   quaternion_alu_top #(.FRAC_BITS(FRAC)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   quat_req_t pending_reqs[$];
   quat_rsp_t expected_rsps[$];
   quat_req_t req_cur;
   quat_req_t req_next;
   logic      req_taken;
   int        accepted_count;
   int        total_items;
   int        error_count;
   int        idle_cycles;
   logic      quiet;

   // ---------------------------------------------------------------- prediction

   // exact 64-bit product, floored by sh fraction bits
   function automatic longint mul_floor(qalu_comp_type p, qalu_comp_type q, int sh);
      longint wide;
      wide = longint'(p) * longint'(q);
      return wide >>> sh;
   endfunction

   function automatic bit out_of_range(longint v);
      return (v > longint'(MAX_Q)) || (v < longint'(MIN_Q));
   endfunction

   function automatic qalu_comp_type clamp32(longint v);
      if (v > longint'(MAX_Q)) return MAX_Q;
      if (v < longint'(MIN_Q)) return MIN_Q;
      return qalu_comp_type'(v[31:0]);
   endfunction

   function automatic quat_rsp_t predict_result(quat_req_t t);
      quat_rsp_t     r;
      longint        sx, sy, sz, sw;
      longint        ex, ey, ez;
      qalu_comp_type cx, cy, cz;
      r = '0;
      case (t.cmd)
         CMD_MUL: begin
            sw = mul_floor(t.aw, t.bw, FRAC) - mul_floor(t.ax, t.bx, FRAC)
               - mul_floor(t.ay, t.by, FRAC) - mul_floor(t.az, t.bz, FRAC);
            sx = mul_floor(t.ax, t.bw, FRAC) + mul_floor(t.bx, t.aw, FRAC)
               + mul_floor(t.ay, t.bz, FRAC) - mul_floor(t.az, t.by, FRAC);
            sy = mul_floor(t.ay, t.bw, FRAC) + mul_floor(t.by, t.aw, FRAC)
               + mul_floor(t.az, t.bx, FRAC) - mul_floor(t.ax, t.bz, FRAC);
            sz = mul_floor(t.az, t.bw, FRAC) + mul_floor(t.bz, t.aw, FRAC)
               + mul_floor(t.ax, t.by, FRAC) - mul_floor(t.ay, t.bx, FRAC);
            r.ov = out_of_range(sw) | out_of_range(sx) | out_of_range(sy) | out_of_range(sz);
            r.rw = clamp32(sw);
            r.rx = clamp32(sx);
            r.ry = clamp32(sy);
            r.rz = clamp32(sz);
         end
         CMD_ROT: begin
            // intermediate cross product, saturated on its own
            ex = mul_floor(t.ay, t.bz, FRAC) - mul_floor(t.az, t.by, FRAC);
            ey = mul_floor(t.az, t.bx, FRAC) - mul_floor(t.ax, t.bz, FRAC);
            ez = mul_floor(t.ax, t.by, FRAC) - mul_floor(t.ay, t.bx, FRAC);
            cx = clamp32(ex);
            cy = clamp32(ey);
            cz = clamp32(ez);
            // doubled terms lose one fraction bit less
            sx = longint'(t.bx) + mul_floor(t.aw, cx, FRAC - 1)
               + mul_floor(t.ay, cz, FRAC - 1) - mul_floor(t.az, cy, FRAC - 1);
            sy = longint'(t.by) + mul_floor(t.aw, cy, FRAC - 1)
               + mul_floor(t.az, cx, FRAC - 1) - mul_floor(t.ax, cz, FRAC - 1);
            sz = longint'(t.bz) + mul_floor(t.aw, cz, FRAC - 1)
               + mul_floor(t.ax, cy, FRAC - 1) - mul_floor(t.ay, cx, FRAC - 1);
            r.ov = out_of_range(ex) | out_of_range(ey) | out_of_range(ez)
                 | out_of_range(sx) | out_of_range(sy) | out_of_range(sz);
            r.rx = clamp32(sx);
            r.ry = clamp32(sy);
            r.rz = clamp32(sz);
            r.rw = '0;
         end
         CMD_CONJ: begin
            sx = -longint'(t.ax);
            sy = -longint'(t.ay);
            sz = -longint'(t.az);
            r.ov = out_of_range(sx) | out_of_range(sy) | out_of_range(sz);
            r.rx = clamp32(sx);
            r.ry = clamp32(sy);
            r.rz = clamp32(sz);
            r.rw = t.aw;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   task automatic add_item(input logic [1:0] cmd,
                           input qalu_comp_type ax, input qalu_comp_type ay,
                           input qalu_comp_type az, input qalu_comp_type aw,
                           input qalu_comp_type bx, input qalu_comp_type by,
                           input qalu_comp_type bz, input qalu_comp_type bw);
      quat_req_t t;
      t.cmd = cmd;
      t.ax = ax; t.ay = ay; t.az = az; t.aw = aw;
      t.bx = bx; t.by = by; t.bz = bz; t.bw = bw;
      t.hold_for_drain = 1'b0;
      pending_reqs.push_back(t);
   endtask

   // mix of extremes, full-range words and values within +/-16
   function automatic qalu_comp_type rand_comp();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return MAX_Q;
               1: return MIN_Q;
               2: return '0;
               3: return 32'sd1;
               4: return ONE;
               default: return -ONE;
            endcase
         end
         1, 2, 3: return qalu_comp_type'($urandom);
         default: return qalu_comp_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   function automatic logic [1:0] rand_cmd();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 33) return CMD_MUL;
      if (pick < 66) return CMD_ROT;
      if (pick < 97) return CMD_CONJ;
      return CMD_UNUSED;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] seen);
      $display("ERROR at %0t: %s expected %h got %h", $time, what, want, seen);
      error_count++;
   endtask

   task automatic check_response(input quat_rsp_t want);
      if (rsp_ch.r_x !== want.rx) report_mismatch("r_x", want.rx, rsp_ch.r_x);
      if (rsp_ch.r_y !== want.ry) report_mismatch("r_y", want.ry, rsp_ch.r_y);
      if (rsp_ch.r_z !== want.rz) report_mismatch("r_z", want.rz, rsp_ch.r_z);
      if (rsp_ch.r_w !== want.rw) report_mismatch("r_w", want.rw, rsp_ch.r_w);
      if (rsp_ch.overflow !== want.ov)
         report_mismatch("overflow", 32'(want.ov), 32'(rsp_ch.overflow));
   endtask

   // ---------------------------------------------------------------- clock

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // no idling on either side through a long middle stretch
   assign quiet = (accepted_count >= 700) && (accepted_count < 1000);

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (!reset) begin
         // hold the current item until it transfers, then load the next or drop valid
         if (!req_ch.valid || req_taken) begin
            if (pending_reqs.size() != 0
                && (!pending_reqs[0].hold_for_drain || expected_rsps.size() == 0)
                && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_next = pending_reqs.pop_front();
               req_cur <= req_next;
               req_ch.cmd <= req_next.cmd;
               req_ch.a_x <= req_next.ax;
               req_ch.a_y <= req_next.ay;
               req_ch.a_z <= req_next.az;
               req_ch.a_w <= req_next.aw;
               req_ch.b_x <= req_next.bx;
               req_ch.b_y <= req_next.by;
               req_ch.b_z <= req_next.bz;
               req_ch.b_w <= req_next.bw;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- monitor and watchdog

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;

         // predict each request transfer
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(predict_result(req_cur));
            accepted_count++;
         end

         // compare each response transfer with the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0)
               report_mismatch("unexpected response r_x", 32'h0, rsp_ch.r_x);
            else
               check_response(expected_rsps.pop_front());
         end

         // count cycles without any transfer
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      quat_req_t t;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_MUL;
      req_ch.a_x = '0; req_ch.a_y = '0; req_ch.a_z = '0; req_ch.a_w = '0;
      req_ch.b_x = '0; req_ch.b_y = '0; req_ch.b_z = '0; req_ch.b_w = '0;
      rsp_ch.ready = 1'b0;
      req_cur = '0;
      error_count = 0;
      accepted_count = 0;

      // directed: identities, basis products, floor rounding, saturation, unused code
      add_item(CMD_MUL, 0, 0, 0, ONE, 0, 0, 0, ONE);
      add_item(CMD_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0);
      add_item(CMD_MUL, 0, ONE, 0, 0, ONE, 0, 0, 0);
      add_item(CMD_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
      add_item(CMD_MUL, 0, 0, 0, -32'sd1, 0, 0, 0, 32'sd1);
      add_item(CMD_MUL, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
      add_item(CMD_MUL, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
      add_item(CMD_MUL, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q);
      add_item(CMD_ROT, 0, 0, HALF_SQRT2, HALF_SQRT2, ONE, 0, 0, 0);
      add_item(CMD_ROT, 0, 0, 0, ONE, 3 * ONE, -2 * ONE, ONE, 32'sd12345);
      add_item(CMD_ROT, 0, 0, 0, 0, ONE, -ONE, MAX_Q, MIN_Q);
      // intermediate cross product saturates
      add_item(CMD_ROT, 0, MAX_Q, 0, 0, 0, 0, MAX_Q, 0);
      add_item(CMD_ROT, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
      add_item(CMD_ROT, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
      add_item(CMD_ROT, -32'sd1, 32'sd1, -32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 0);
      // negating the most negative value saturates
      add_item(CMD_CONJ, MIN_Q, MIN_Q, MIN_Q, MIN_Q, ONE, ONE, ONE, ONE);
      add_item(CMD_CONJ, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 0, 0, 0, 0);
      add_item(CMD_CONJ, 0, 0, 0, 0, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
      add_item(CMD_CONJ, 32'sd1, -32'sd1, ONE, -ONE, 0, 0, 0, 0);
      add_item(CMD_UNUSED, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
      add_item(CMD_UNUSED, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q);

      // random items; a few wait for the block to drain first
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         t.cmd = rand_cmd();
         t.ax = rand_comp(); t.ay = rand_comp(); t.az = rand_comp(); t.aw = rand_comp();
         t.bx = rand_comp(); t.by = rand_comp(); t.bz = rand_comp(); t.bw = rand_comp();
         t.hold_for_drain = (i == 0) || (i == 500) || (i == 1200);
         pending_reqs.push_back(t);
      end
      total_items = pending_reqs.size();

      // release reset
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // wait for every request to transfer and every response to arrive
      while (accepted_count < total_items || expected_rsps.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
